FILE: rtl/core/u8se_pkg.sv
// Package for the UTF-8 sanitiser: controller/datapath structs, escape characters
// and the lead-byte and hex-digit helpers.
// No dependencies.
package u8se_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// index of the character within a six-character escape
	localparam logic [2:0] ESC_BSLASH = 3'd0;
	localparam logic [2:0] ESC_X      = 3'd1;
	localparam logic [2:0] ESC_LBRACE = 3'd2;
	localparam logic [2:0] ESC_HI     = 3'd3;
	localparam logic [2:0] ESC_LO     = 3'd4;
	localparam logic [2:0] ESC_RBRACE = 3'd5;

	localparam logic [20:0] CP_MIN3     = 21'h000800;
	localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
	localparam logic [20:0] CP_MIN4     = 21'h010000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;

	typedef struct packed {
		logic load;    // take the input word into the buffer
		logic decide;  // latch the action for the head sequence
		logic emit;    // produce one output character
	} u8se_cmd_t;

	typedef struct packed {
		logic empty;      // nothing pending
		logic stall;      // head sequence incomplete, more bytes needed
		logic out_free;   // output register can take a character
		logic last_emit;  // this character closes the current action
	} u8se_stat_t;

	// expected sequence length from the lead byte, 0 for an invalid lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] r;
		if (b[7] == 1'b0)
			r = 3'd1;
		else if (b[7:5] == 3'b110)
			r = 3'd2;
		else if (b[7:4] == 4'b1110)
			r = 3'd3;
		else if (b[7:3] == 5'b11110)
			r = 3'd4;
		else
			r = 3'd0;
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10)
			r = 8'h30 + {4'd0, v};
		else
			r = 8'h57 + {4'd0, v};
		return r;
	endfunction

	function automatic logic [7:0] esc_char(input logic [2:0] idx, input logic [7:0] b);
		logic [7:0] r;
		case (idx)
			ESC_BSLASH: r = CH_BSLASH;
			ESC_X:      r = CH_X;
			ESC_LBRACE: r = CH_LBRACE;
			ESC_HI:     r = hex_digit(b[7:4]);
			ESC_LO:     r = hex_digit(b[3:0]);
			ESC_RBRACE: r = CH_RBRACE;
			default:    r = CH_RBRACE;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/u8se_ctrl.sv
// Controller of the UTF-8 sanitiser: sequences load, decide and emit steps.
// Depends on u8se_pkg.
module u8se_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  u8se_pkg::u8se_stat_t  stat,
	output u8se_pkg::u8se_cmd_t   cmd
);
	import u8se_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_EMIT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.decide = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.empty || stat.stall) begin
					state_d = S_IDLE;
				end else begin
					cmd.decide = 1'b1;
					state_d    = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last_emit)
						state_d = S_DECIDE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/core/u8se_dp.sv
// Datapath of the UTF-8 sanitiser: byte buffer, sequence check, escape
// generator and output register.
// Depends on u8se_pkg.
module u8se_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u8se_pkg::u8se_cmd_t   cmd,
	output u8se_pkg::u8se_stat_t  stat,
	input  logic [7:0]            in_byte,
	input  logic                  in_final,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  run_end,
	output logic                  text_end
);
	import u8se_pkg::*;

	logic [7:0]  buf_q [4];
	logic [2:0]  cnt_q;
	logic        fin_q;
	logic [2:0]  rem_q;
	logic [2:0]  chr_q;
	logic        esc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_end_q;
	logic        text_end_q;

	logic [2:0]  len0;
	logic [2:0]  len1;
	logic [2:0]  cnt_m1;
	logic [20:0] cp;
	logic        conts_ok;
	logic        range_ok;
	logic        seq_ok;
	logic        printable;
	logic        byte_done;
	logic        more;
	logic        last_char;
	logic [7:0]  char_d;

	assign len0   = lead_len(buf_q[0]);
	assign len1   = lead_len(buf_q[1]);
	assign cnt_m1 = cnt_q - 3'd1;

	always_comb begin
		cp       = {13'd0, buf_q[0]};
		conts_ok = 1'b1;
		range_ok = 1'b1;
		case (len0)
			3'd2: begin
				cp       = {10'd0, buf_q[0][4:0], buf_q[1][5:0]};
				conts_ok = (buf_q[1][7:6] == 2'b10);
				range_ok = (cp >= 21'h80);
			end
			3'd3: begin
				cp       = {5'd0, buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]};
				conts_ok = (buf_q[1][7:6] == 2'b10) && (buf_q[2][7:6] == 2'b10);
				range_ok = (cp >= CP_MIN3) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
			end
			3'd4: begin
				cp       = {buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
				conts_ok = (buf_q[1][7:6] == 2'b10) && (buf_q[2][7:6] == 2'b10)
					&& (buf_q[3][7:6] == 2'b10);
				range_ok = (cp >= CP_MIN4) && (cp <= CP_MAX);
			end
			default: begin
				cp       = {13'd0, buf_q[0]};
				conts_ok = 1'b1;
				range_ok = 1'b1;
			end
		endcase
	end

	assign seq_ok    = (len0 != 3'd0) && (cnt_q >= len0) && conts_ok && range_ok;
	assign printable = !((cp < 21'h20) || (cp == 21'h7F) || ((cp >= 21'h80) && (cp <= 21'h9F)));

	assign byte_done = !esc_q || (chr_q == ESC_RBRACE);
	assign last_char = byte_done && (rem_q == 3'd1);
	// does the rest of the buffer still produce output in this step
	assign more      = (cnt_m1 != 3'd0) && (fin_q || (len1 == 3'd0) || (cnt_m1 >= len1));
	assign char_d    = esc_q ? esc_char(chr_q, buf_q[0]) : buf_q[0];

	assign stat.empty     = (cnt_q == 3'd0);
	assign stat.stall     = (len0 != 3'd0) && (cnt_q < len0) && !fin_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.last_emit = last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			fin_q <= 1'b0;
			rem_q <= 3'd0;
			chr_q <= 3'd0;
			esc_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= cnt_q + 3'd1;
				fin_q <= in_final;
			end
			if (cmd.decide) begin
				rem_q <= seq_ok ? len0 : 3'd1;
				esc_q <= !(seq_ok && printable);
				chr_q <= 3'd0;
			end
			if (cmd.emit) begin
				if (byte_done) begin
					cnt_q <= cnt_m1;
					rem_q <= rem_q - 3'd1;
					chr_q <= 3'd0;
				end else begin
					chr_q <= chr_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			buf_q[cnt_q[1:0]] <= in_byte;
		if (cmd.emit && byte_done) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= char_d;
			run_end_q  <= last_char && !more;
			text_end_q <= last_char && !more && fin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;
	assign text_end  = text_end_q;

endmodule

FILE: rtl/core/utf8_sanitize_escape_top.sv
// Strict UTF-8 sanitiser with hex escapes of control code points and bad bytes.
// Slave stream of raw string bytes, s_tlast on the final byte; master stream of
// output text bytes, m_tuser on the last word caused by an input word, m_tlast
// on the last word of the string.
// A word is taken only while the controller is idle. After it is taken, one
// decide cycle judges the head sequence; a decided sequence then puts one word
// a cycle into the output register while it is free: one per passed byte, six
// per escaped byte, followed by a further decide cycle. The first output word
// is registered by the first emit after the decide cycle. A byte that leaves
// its sequence incomplete gives no output; the controller goes back to idle.
// The next input word is taken in the idle state that the last decide cycle
// of the step returns to.
// Up to three bytes stay pending between input words; the final byte flushes
// them all.
// A stalled receiver holds the output register and stops the emit sequence;
// no input word is taken until the last word of the step has entered the
// output register.
// Reset empties the pending buffer and the output register at once.
// Depends on u8se_pkg, u8se_ctrl, u8se_dp.
module utf8_sanitize_escape_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] run_end
	output logic       m_tlast    // text_end
);
	import u8se_pkg::*;

	u8se_cmd_t  cmd;
	u8se_stat_t stat;

	u8se_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	u8se_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.in_final  (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.run_end   (m_tuser),
		.text_end  (m_tlast)
	);

	// end of string is always also end of the run for that word
	a_text_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("text end without run end");

	// a decided action never starts on an empty or incomplete buffer
	a_decide_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> !stat.empty && !stat.stall)
		else $error("decide on empty or stalled buffer");

	// a freshly loaded word leaves the buffer non-empty
	a_load_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !stat.empty)
		else $error("buffer empty after load");

	// an emit only happens while the output register can take the word
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("emit into a full output register");

endmodule
